// File: rtl/core/bmvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bmvg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIM_W     = 24;
    localparam int POS_W     = 25;
    localparam int TEX_W     = FRAC_BITS + 1;
    localparam int IDX_W     = 19;
    localparam int COORD_W   = 8;
    localparam int FACE_W    = 3;
    localparam int AXIS_W    = 2;
    localparam int SEG_MAX_W = 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_DEPTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SEGMENTS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SEGMENTS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SEGMENTS  = 3'd5;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    typedef struct packed {
        logic [AXIS_W-1:0] u_axis;
        logic [AXIS_W-1:0] v_axis;
        logic [AXIS_W-1:0] n_axis;
        logic              u_neg;
        logic              v_neg;
    } t_face;

    // sideband that rides along the dividers
    typedef struct packed {
        logic                 valid;
        logic [FACE_W-1:0]    face;
        logic [COORD_W-1:0]   ix;
        logic [COORD_W-1:0]   iy;
        logic [SEG_MAX_W-1:0] seg_w;
        logic [SEG_MAX_W-1:0] seg_h;
        logic [SEG_MAX_W-1:0] seg_d;
        logic [DIM_W-1:0]     ext_x;
        logic [DIM_W-1:0]     ext_y;
        logic [DIM_W-1:0]     ext_z;
    } t_side;

    function automatic t_face face_desc(input logic [FACE_W-1:0] f);
        t_face d;
        case (f)
            FACE_POS_X: d = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b1, 1'b1};
            FACE_NEG_X: d = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b0, 1'b1};
            FACE_POS_Y: d = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b0};
            FACE_NEG_Y: d = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b1};
            FACE_POS_Z: d = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b0, 1'b1};
            default:    d = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b1, 1'b1};
        endcase
        return d;
    endfunction

    function automatic logic [DIM_W-1:0] sel_ext(input logic [AXIS_W-1:0] a,
                                                 input logic [DIM_W-1:0] x,
                                                 input logic [DIM_W-1:0] y,
                                                 input logic [DIM_W-1:0] z);
        logic [DIM_W-1:0] r;
        case (a)
            AXIS_X:  r = x;
            AXIS_Y:  r = y;
            default: r = z;
        endcase
        return r;
    endfunction

    function automatic logic [SEG_MAX_W-1:0] sel_seg(input logic [AXIS_W-1:0] a,
                                                     input logic [SEG_MAX_W-1:0] x,
                                                     input logic [SEG_MAX_W-1:0] y,
                                                     input logic [SEG_MAX_W-1:0] z);
        logic [SEG_MAX_W-1:0] r;
        case (a)
            AXIS_X:  r = x;
            AXIS_Y:  r = y;
            default: r = z;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/box_mesh_vertex_generator.sv
// The dividers work on TW = max(24, FRAC_BITS + 8) bits, 24 at the default parameters.
// Throughput: one grid point per cycle; busy stays low, the restoring dividers are
// fully pipelined at one quotient bit per stage and the receiver cannot stall.
// Reset (synchronous, active low) clears the pipeline valid bits, sets extents to 1.0 and
// every segment count to 1.
`timescale 1ns / 1ps
`default_nettype none
module box_mesh_vertex_generator #(
    parameter int SEGMENT_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bmvg_pkg::FACE_W-1:0]         i_face,
    input  logic [bmvg_pkg::COORD_W-1:0]        i_column,
    input  logic [bmvg_pkg::COORD_W-1:0]        i_row,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bmvg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bmvg_pkg::DIM_W-1:0]          i_cfg_data,
    output logic                                o_strobe,
    output logic signed [bmvg_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [bmvg_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [bmvg_pkg::POS_W-1:0]   o_pos_z,
    output logic [bmvg_pkg::AXIS_W-1:0]         o_normal_axis,
    output logic                                o_normal_negative,
    output logic [bmvg_pkg::TEX_W-1:0]          o_tex_u,
    output logic [bmvg_pkg::TEX_W-1:0]          o_tex_v,
    output logic                                o_quad_valid,
    output logic [bmvg_pkg::IDX_W-1:0]          o_corner_a,
    output logic [bmvg_pkg::IDX_W-1:0]          o_corner_b,
    output logic [bmvg_pkg::IDX_W-1:0]          o_corner_c,
    output logic [bmvg_pkg::IDX_W-1:0]          o_corner_d
);
    import bmvg_pkg::*;

    localparam int TW = (DIM_W > COORD_W + FRAC_BITS) ? DIM_W : COORD_W + FRAC_BITS;
    localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1) << FRAC_BITS;

    logic [DIM_W-1:0]        r_box_width;
    logic [DIM_W-1:0]        r_box_height;
    logic [DIM_W-1:0]        r_box_depth;
    logic [SEGMENT_BITS-1:0] r_width_segments;
    logic [SEGMENT_BITS-1:0] r_height_segments;
    logic [SEGMENT_BITS-1:0] r_depth_segments;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width       <= DIM_ONE;
            r_box_height      <= DIM_ONE;
            r_box_depth       <= DIM_ONE;
            r_width_segments  <= SEGMENT_BITS'(1);
            r_height_segments <= SEGMENT_BITS'(1);
            r_depth_segments  <= SEGMENT_BITS'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BOX_WIDTH:       r_box_width       <= i_cfg_data;
                CFG_BOX_HEIGHT:      r_box_height      <= i_cfg_data;
                CFG_BOX_DEPTH:       r_box_depth       <= i_cfg_data;
                CFG_WIDTH_SEGMENTS:  r_width_segments  <= i_cfg_data[SEGMENT_BITS-1:0];
                CFG_HEIGHT_SEGMENTS: r_height_segments <= i_cfg_data[SEGMENT_BITS-1:0];
                CFG_DEPTH_SEGMENTS:  r_depth_segments  <= i_cfg_data[SEGMENT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    t_side                   side_s1;
    logic [TW-1:0]           dvd_seg_u;
    logic [TW-1:0]           dvd_seg_v;
    logic [TW-1:0]           dvd_tex_u;
    logic [TW-1:0]           dvd_tex_v;
    logic [SEGMENT_BITS-1:0] dvs_u;
    logic [SEGMENT_BITS-1:0] dvs_v;
    logic [TW-1:0]           q_seg_u;
    logic [TW-1:0]           q_seg_v;
    logic [TW-1:0]           q_tex_u;
    logic [TW-1:0]           q_tex_v;

    bmvg_front #(
        .SEGMENT_BITS (SEGMENT_BITS),
        .TW           (TW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (start && !busy),
        .i_face      (i_face),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_ext_x     (r_box_width),
        .i_ext_y     (r_box_height),
        .i_ext_z     (r_box_depth),
        .i_seg_w     (r_width_segments),
        .i_seg_h     (r_height_segments),
        .i_seg_d     (r_depth_segments),
        .o_side      (side_s1),
        .o_dvd_seg_u (dvd_seg_u),
        .o_dvd_seg_v (dvd_seg_v),
        .o_dvd_tex_u (dvd_tex_u),
        .o_dvd_tex_v (dvd_tex_v),
        .o_dvs_u     (dvs_u),
        .o_dvs_v     (dvs_v)
    );

    bmvg_div #(.DW(TW), .VW(SEGMENT_BITS)) u_div_seg_u (
        .i_clk      (i_clk),
        .i_dividend (dvd_seg_u),
        .i_divisor  (dvs_u),
        .o_quotient (q_seg_u)
    );

    bmvg_div #(.DW(TW), .VW(SEGMENT_BITS)) u_div_seg_v (
        .i_clk      (i_clk),
        .i_dividend (dvd_seg_v),
        .i_divisor  (dvs_v),
        .o_quotient (q_seg_v)
    );

    bmvg_div #(.DW(TW), .VW(SEGMENT_BITS)) u_div_tex_u (
        .i_clk      (i_clk),
        .i_dividend (dvd_tex_u),
        .i_divisor  (dvs_u),
        .o_quotient (q_tex_u)
    );

    bmvg_div #(.DW(TW), .VW(SEGMENT_BITS)) u_div_tex_v (
        .i_clk      (i_clk),
        .i_dividend (dvd_tex_v),
        .i_divisor  (dvs_v),
        .o_quotient (q_tex_v)
    );

    // sideband delay matched to the divider depth
    t_side r_dly [0:TW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TW; k++) begin
                r_dly[k].valid <= 1'b0;
            end
        end else begin
            r_dly[0] <= side_s1;
            for (int k = 1; k < TW; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    bmvg_back #(
        .TW (TW)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_side            (r_dly[TW-1]),
        .i_q_seg_u         (q_seg_u),
        .i_q_seg_v         (q_seg_v),
        .i_q_tex_u         (q_tex_u),
        .i_q_tex_v         (q_tex_v),
        .o_strobe          (o_strobe),
        .o_pos_x           (o_pos_x),
        .o_pos_y           (o_pos_y),
        .o_pos_z           (o_pos_z),
        .o_normal_axis     (o_normal_axis),
        .o_normal_negative (o_normal_negative),
        .o_tex_u           (o_tex_u),
        .o_tex_v           (o_tex_v),
        .o_quad_valid      (o_quad_valid),
        .o_corner_a        (o_corner_a),
        .o_corner_b        (o_corner_b),
        .o_corner_c        (o_corner_c),
        .o_corner_d        (o_corner_d)
    );

endmodule
`default_nettype wire

// File: rtl/core/bmvg_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bmvg_div #(
    parameter int DW = 24,
    parameter int VW = 8
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient
);

    logic [VW-1:0] r_rem [0:DW-1];
    logic [DW-1:0] r_quo [0:DW-1];
    logic [DW-1:0] r_dvd [0:DW-1];
    logic [VW-1:0] r_dvs [0:DW-1];

    genvar k;
    generate
        for (k = 0; k < DW; k++) begin : g_stage
            logic [VW-1:0] rem_i;
            logic [DW-1:0] quo_i;
            logic [DW-1:0] dvd_i;
            logic [VW-1:0] dvs_i;
            logic [VW:0]   trial;
            logic [VW:0]   diff;
            logic          take;

            if (k == 0) begin : g_first
                assign rem_i = '0;
                assign quo_i = '0;
                assign dvd_i = i_dividend;
                assign dvs_i = i_divisor;
            end else begin : g_next
                assign rem_i = r_rem[k-1];
                assign quo_i = r_quo[k-1];
                assign dvd_i = r_dvd[k-1];
                assign dvs_i = r_dvs[k-1];
            end

            assign trial = {rem_i, dvd_i[DW-1]};
            assign take  = trial >= {1'b0, dvs_i};
            assign diff  = trial - {1'b0, dvs_i};

            always_ff @(posedge i_clk) begin
                r_rem[k] <= take ? diff[VW-1:0] : trial[VW-1:0];
                r_quo[k] <= {quo_i[DW-2:0], take};
                r_dvd[k] <= dvd_i << 1;
                r_dvs[k] <= dvs_i;
            end
        end
    endgenerate

    assign o_quotient = r_quo[DW-1];

endmodule
`default_nettype wire

// File: rtl/core/bmvg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bmvg_front #(
    parameter int SEGMENT_BITS = 8,
    parameter int TW           = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic [bmvg_pkg::FACE_W-1:0]          i_face,
    input  logic [bmvg_pkg::COORD_W-1:0]         i_column,
    input  logic [bmvg_pkg::COORD_W-1:0]         i_row,
    input  logic [bmvg_pkg::DIM_W-1:0]           i_ext_x,
    input  logic [bmvg_pkg::DIM_W-1:0]           i_ext_y,
    input  logic [bmvg_pkg::DIM_W-1:0]           i_ext_z,
    input  logic [SEGMENT_BITS-1:0]              i_seg_w,
    input  logic [SEGMENT_BITS-1:0]              i_seg_h,
    input  logic [SEGMENT_BITS-1:0]              i_seg_d,
    output bmvg_pkg::t_side                      o_side,
    output logic [TW-1:0]                        o_dvd_seg_u,
    output logic [TW-1:0]                        o_dvd_seg_v,
    output logic [TW-1:0]                        o_dvd_tex_u,
    output logic [TW-1:0]                        o_dvd_tex_v,
    output logic [SEGMENT_BITS-1:0]              o_dvs_u,
    output logic [SEGMENT_BITS-1:0]              o_dvs_v
);
    import bmvg_pkg::*;

    logic [FACE_W-1:0]       face_c;
    t_face                   fd;
    logic [SEGMENT_BITS-1:0] sw;
    logic [SEGMENT_BITS-1:0] sh;
    logic [SEGMENT_BITS-1:0] sd;
    logic [SEG_MAX_W-1:0]    gu;
    logic [SEG_MAX_W-1:0]    gv;
    logic [COORD_W-1:0]      ix;
    logic [COORD_W-1:0]      iy;
    t_side                   n_side;

    t_side                   r_side;
    logic [TW-1:0]           r_dvd_seg_u;
    logic [TW-1:0]           r_dvd_seg_v;
    logic [TW-1:0]           r_dvd_tex_u;
    logic [TW-1:0]           r_dvd_tex_v;
    logic [SEGMENT_BITS-1:0] r_dvs_u;
    logic [SEGMENT_BITS-1:0] r_dvs_v;

    always_comb begin
        face_c = (i_face > FACE_NEG_Z) ? FACE_NEG_Z : i_face;
        fd     = face_desc(face_c);
        sw     = (i_seg_w == '0) ? SEGMENT_BITS'(1) : i_seg_w;
        sh     = (i_seg_h == '0) ? SEGMENT_BITS'(1) : i_seg_h;
        sd     = (i_seg_d == '0) ? SEGMENT_BITS'(1) : i_seg_d;
        gu     = sel_seg(fd.u_axis, SEG_MAX_W'(sw), SEG_MAX_W'(sh), SEG_MAX_W'(sd));
        gv     = sel_seg(fd.v_axis, SEG_MAX_W'(sw), SEG_MAX_W'(sh), SEG_MAX_W'(sd));
        ix     = (SEG_MAX_W'(i_column) > gu) ? gu[COORD_W-1:0] : i_column;
        iy     = (SEG_MAX_W'(i_row) > gv) ? gv[COORD_W-1:0] : i_row;

        n_side       = '0;
        n_side.valid = i_accept;
        n_side.face  = face_c;
        n_side.ix    = ix;
        n_side.iy    = iy;
        n_side.seg_w = SEG_MAX_W'(sw);
        n_side.seg_h = SEG_MAX_W'(sh);
        n_side.seg_d = SEG_MAX_W'(sd);
        n_side.ext_x = i_ext_x;
        n_side.ext_y = i_ext_y;
        n_side.ext_z = i_ext_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else begin
            r_side <= n_side;
        end
        r_dvd_seg_u <= TW'(sel_ext(fd.u_axis, i_ext_x, i_ext_y, i_ext_z));
        r_dvd_seg_v <= TW'(sel_ext(fd.v_axis, i_ext_x, i_ext_y, i_ext_z));
        r_dvd_tex_u <= TW'({ix, {FRAC_BITS{1'b0}}});
        r_dvd_tex_v <= TW'({iy, {FRAC_BITS{1'b0}}});
        r_dvs_u     <= gu[SEGMENT_BITS-1:0];
        r_dvs_v     <= gv[SEGMENT_BITS-1:0];
    end

    assign o_side      = r_side;
    assign o_dvd_seg_u = r_dvd_seg_u;
    assign o_dvd_seg_v = r_dvd_seg_v;
    assign o_dvd_tex_u = r_dvd_tex_u;
    assign o_dvd_tex_v = r_dvd_tex_v;
    assign o_dvs_u     = r_dvs_u;
    assign o_dvs_v     = r_dvs_v;

endmodule
`default_nettype wire

// File: rtl/core/bmvg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bmvg_back #(
    parameter int TW = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bmvg_pkg::t_side                     i_side,
    input  logic [TW-1:0]                       i_q_seg_u,
    input  logic [TW-1:0]                       i_q_seg_v,
    input  logic [TW-1:0]                       i_q_tex_u,
    input  logic [TW-1:0]                       i_q_tex_v,
    output logic                                o_strobe,
    output logic signed [bmvg_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [bmvg_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [bmvg_pkg::POS_W-1:0]   o_pos_z,
    output logic [bmvg_pkg::AXIS_W-1:0]         o_normal_axis,
    output logic                                o_normal_negative,
    output logic [bmvg_pkg::TEX_W-1:0]          o_tex_u,
    output logic [bmvg_pkg::TEX_W-1:0]          o_tex_v,
    output logic                                o_quad_valid,
    output logic [bmvg_pkg::IDX_W-1:0]          o_corner_a,
    output logic [bmvg_pkg::IDX_W-1:0]          o_corner_b,
    output logic [bmvg_pkg::IDX_W-1:0]          o_corner_c,
    output logic [bmvg_pkg::IDX_W-1:0]          o_corner_d
);
    import bmvg_pkg::*;

    localparam int MUL_W = COORD_W + DIM_W;
    localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(1) << FRAC_BITS;

    // stage A: products
    t_face                fd;
    logic [SEG_MAX_W-1:0] gu;
    logic [SEG_MAX_W-1:0] gv;
    logic [MUL_W-1:0]     mul_u;
    logic [MUL_W-1:0]     mul_v;

    logic                 r_a_valid;
    logic [FACE_W-1:0]    r_a_face;
    t_face                r_a_fd;
    logic [COORD_W-1:0]   r_a_ix;
    logic                 r_a_qv;
    logic [IDX_W-1:0]     r_a_stride;
    logic [POS_W-1:0]     r_a_prod_u;
    logic [POS_W-1:0]     r_a_prod_v;
    logic [DIM_W-1:0]     r_a_half_u;
    logic [DIM_W-1:0]     r_a_half_v;
    logic [DIM_W-1:0]     r_a_half_n;
    logic [IDX_W-1:0]     r_a_px;
    logic [IDX_W-1:0]     r_a_py;
    logic [IDX_W-1:0]     r_a_pz;
    logic [IDX_W-1:0]     r_a_siy;
    logic [TEX_W-1:0]     r_a_tu;
    logic [TEX_W-1:0]     r_a_tqv;

    always_comb begin
        fd    = face_desc(i_side.face);
        gu    = sel_seg(fd.u_axis, i_side.seg_w, i_side.seg_h, i_side.seg_d);
        gv    = sel_seg(fd.v_axis, i_side.seg_w, i_side.seg_h, i_side.seg_d);
        mul_u = MUL_W'(i_side.ix) * MUL_W'(i_q_seg_u[DIM_W-1:0]);
        mul_v = MUL_W'(i_side.iy) * MUL_W'(i_q_seg_v[DIM_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_side.valid;
        end
        r_a_face   <= i_side.face;
        r_a_fd     <= fd;
        r_a_ix     <= i_side.ix;
        r_a_qv     <= (SEG_MAX_W'(i_side.ix) < gu) && (SEG_MAX_W'(i_side.iy) < gv);
        r_a_stride <= IDX_W'(gu) + IDX_W'(1);
        r_a_prod_u <= mul_u[POS_W-1:0];
        r_a_prod_v <= mul_v[POS_W-1:0];
        r_a_half_u <= sel_ext(fd.u_axis, i_side.ext_x, i_side.ext_y, i_side.ext_z) >> 1;
        r_a_half_v <= sel_ext(fd.v_axis, i_side.ext_x, i_side.ext_y, i_side.ext_z) >> 1;
        r_a_half_n <= sel_ext(fd.n_axis, i_side.ext_x, i_side.ext_y, i_side.ext_z) >> 1;
        r_a_px     <= IDX_W'((IDX_W'(i_side.seg_d) + IDX_W'(1)) *
                             (IDX_W'(i_side.seg_h) + IDX_W'(1)));
        r_a_py     <= IDX_W'((IDX_W'(i_side.seg_w) + IDX_W'(1)) *
                             (IDX_W'(i_side.seg_d) + IDX_W'(1)));
        r_a_pz     <= IDX_W'((IDX_W'(i_side.seg_w) + IDX_W'(1)) *
                             (IDX_W'(i_side.seg_h) + IDX_W'(1)));
        r_a_siy    <= IDX_W'((IDX_W'(gu) + IDX_W'(1)) * IDX_W'(i_side.iy));
        r_a_tu     <= i_q_tex_u[TEX_W-1:0];
        r_a_tqv    <= i_q_tex_v[TEX_W-1:0];
    end

    // stage B: coordinates, face base
    logic [POS_W-1:0] cu;
    logic [POS_W-1:0] cv;
    logic [POS_W-1:0] cu_s;
    logic [POS_W-1:0] cv_s;
    logic [POS_W-1:0] cn;
    logic [POS_W-1:0] n_pos [0:2];
    logic [IDX_W-1:0] n_base;

    logic             r_b_valid;
    logic [POS_W-1:0] r_b_pos_x;
    logic [POS_W-1:0] r_b_pos_y;
    logic [POS_W-1:0] r_b_pos_z;
    logic [AXIS_W-1:0] r_b_naxis;
    logic             r_b_neg;
    logic [TEX_W-1:0] r_b_tu;
    logic [TEX_W-1:0] r_b_tv;
    logic             r_b_qv;
    logic [IDX_W-1:0] r_b_base;
    logic [IDX_W-1:0] r_b_lin;
    logic [IDX_W-1:0] r_b_stride;

    always_comb begin
        cu   = r_a_prod_u - POS_W'(r_a_half_u);
        cv   = r_a_prod_v - POS_W'(r_a_half_v);
        cu_s = r_a_fd.u_neg ? (POS_W'(0) - cu) : cu;
        cv_s = r_a_fd.v_neg ? (POS_W'(0) - cv) : cv;
        cn   = r_a_face[0] ? (POS_W'(0) - POS_W'(r_a_half_n)) : POS_W'(r_a_half_n);
        for (int k = 0; k < 3; k++) begin
            if (r_a_fd.u_axis == AXIS_W'(k)) begin
                n_pos[k] = cu_s;
            end else if (r_a_fd.v_axis == AXIS_W'(k)) begin
                n_pos[k] = cv_s;
            end else begin
                n_pos[k] = cn;
            end
        end
        case (r_a_face)
            FACE_POS_X: n_base = '0;
            FACE_NEG_X: n_base = r_a_px;
            FACE_POS_Y: n_base = r_a_px << 1;
            FACE_NEG_Y: n_base = (r_a_px << 1) + r_a_py;
            FACE_POS_Z: n_base = (r_a_px + r_a_py) << 1;
            default:    n_base = ((r_a_px + r_a_py) << 1) + r_a_pz;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_pos_x  <= n_pos[0];
        r_b_pos_y  <= n_pos[1];
        r_b_pos_z  <= n_pos[2];
        r_b_naxis  <= r_a_fd.n_axis;
        r_b_neg    <= r_a_face[0];
        r_b_tu     <= r_a_tu;
        r_b_tv     <= TEX_ONE - r_a_tqv;
        r_b_qv     <= r_a_qv;
        r_b_base   <= n_base;
        r_b_lin    <= IDX_W'(r_a_ix) + r_a_siy;
        r_b_stride <= r_a_stride;
    end

    // stage C: first corner
    logic              r_c_valid;
    logic [POS_W-1:0]  r_c_pos_x;
    logic [POS_W-1:0]  r_c_pos_y;
    logic [POS_W-1:0]  r_c_pos_z;
    logic [AXIS_W-1:0] r_c_naxis;
    logic              r_c_neg;
    logic [TEX_W-1:0]  r_c_tu;
    logic [TEX_W-1:0]  r_c_tv;
    logic              r_c_qv;
    logic [IDX_W-1:0]  r_c_a;
    logic [IDX_W-1:0]  r_c_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_pos_x  <= r_b_pos_x;
        r_c_pos_y  <= r_b_pos_y;
        r_c_pos_z  <= r_b_pos_z;
        r_c_naxis  <= r_b_naxis;
        r_c_neg    <= r_b_neg;
        r_c_tu     <= r_b_tu;
        r_c_tv     <= r_b_tv;
        r_c_qv     <= r_b_qv;
        r_c_a      <= r_b_base + r_b_lin;
        r_c_stride <= r_b_stride;
    end

    // stage D: output register
    logic [IDX_W-1:0]  c_b;
    logic              r_d_valid;
    logic [POS_W-1:0]  r_d_pos_x;
    logic [POS_W-1:0]  r_d_pos_y;
    logic [POS_W-1:0]  r_d_pos_z;
    logic [AXIS_W-1:0] r_d_naxis;
    logic              r_d_neg;
    logic [TEX_W-1:0]  r_d_tu;
    logic [TEX_W-1:0]  r_d_tv;
    logic              r_d_qv;
    logic [IDX_W-1:0]  r_d_a;
    logic [IDX_W-1:0]  r_d_b;
    logic [IDX_W-1:0]  r_d_c;
    logic [IDX_W-1:0]  r_d_d;

    assign c_b = r_c_a + r_c_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
        r_d_pos_x <= r_c_pos_x;
        r_d_pos_y <= r_c_pos_y;
        r_d_pos_z <= r_c_pos_z;
        r_d_naxis <= r_c_naxis;
        r_d_neg   <= r_c_neg;
        r_d_tu    <= r_c_tu;
        r_d_tv    <= r_c_tv;
        r_d_qv    <= r_c_qv;
        r_d_a     <= r_c_qv ? r_c_a : '0;
        r_d_b     <= r_c_qv ? c_b : '0;
        r_d_c     <= r_c_qv ? (c_b + IDX_W'(1)) : '0;
        r_d_d     <= r_c_qv ? (r_c_a + IDX_W'(1)) : '0;
    end

    assign o_strobe          = r_d_valid;
    assign o_pos_x           = r_d_pos_x;
    assign o_pos_y           = r_d_pos_y;
    assign o_pos_z           = r_d_pos_z;
    assign o_normal_axis     = r_d_naxis;
    assign o_normal_negative = r_d_neg;
    assign o_tex_u           = r_d_tu;
    assign o_tex_v           = r_d_tv;
    assign o_quad_valid      = r_d_qv;
    assign o_corner_a        = r_d_a;
    assign o_corner_b        = r_d_b;
    assign o_corner_c        = r_d_c;
    assign o_corner_d        = r_d_d;

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import bmvg_pkg::*;

    localparam int LATENCY     = 28;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [AXIS_W-1:0]       normal_axis;
        logic                    normal_negative;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
        logic                    quad_valid;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
        logic [IDX_W-1:0]        corner_d;
    } t_vertex;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [FACE_W-1:0]    i_face;
    logic [COORD_W-1:0]   i_column;
    logic [COORD_W-1:0]   i_row;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;
    logic                 o_strobe;
    logic signed [POS_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic [AXIS_W-1:0]    o_normal_axis;
    logic                 o_normal_negative;
    logic [TEX_W-1:0]     o_tex_u, o_tex_v;
    logic                 o_quad_valid;
    logic [IDX_W-1:0]     o_corner_a, o_corner_b, o_corner_c, o_corner_d;

    box_mesh_vertex_generator i_dut (.*);

    // predictor state
    logic [DIM_W-1:0] extent_q [3];
    logic [7:0]       segs_q [3];
    t_vertex          vertex_q [$];
    int               error_count = 0;
    int               cycle_count = 0;
    bit               idle_enable = 1;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int seg_of(int axis);
        return (segs_q[axis] == 0) ? 1 : segs_q[axis];
    endfunction

    function automatic int u_axis_of(int f);
        return (f < 2) ? 2 : 0;
    endfunction

    function automatic int v_axis_of(int f);
        return (f == 2 || f == 3) ? 2 : 1;
    endfunction

    function automatic longint grid_coord(int axis, int i);
        longint ext;
        ext = extent_q[axis];
        return longint'(i) * (ext / seg_of(axis)) - ext / 2;
    endfunction

    function automatic t_vertex predict_vertex(int face_in, int col, int rw);
        t_vertex v;
        longint  p [3];
        int      f, ua, va, na, gu, gv, ix, iy, ud, vd;
        longint  base, stride;
        f  = (face_in > 5) ? 5 : face_in;
        ua = u_axis_of(f);
        va = v_axis_of(f);
        na = f / 2;
        ud = (f == 0 || f == 5) ? -1 : 1;
        vd = (f == 2) ? 1 : -1;
        gu = seg_of(ua);
        gv = seg_of(va);
        ix = (col > gu) ? gu : col;
        iy = (rw > gv) ? gv : rw;
        p[ua] = grid_coord(ua, ix) * ud;
        p[va] = grid_coord(va, iy) * vd;
        p[na] = (f & 1) ? -(longint'(extent_q[na]) / 2) : longint'(extent_q[na]) / 2;
        v.pos_x = POS_W'(p[0]);
        v.pos_y = POS_W'(p[1]);
        v.pos_z = POS_W'(p[2]);
        v.normal_axis = AXIS_W'(na);
        v.normal_negative = ((f & 1) != 0);
        v.tex_u = TEX_W'((longint'(ix) << FRAC_BITS) / gu);
        v.tex_v = TEX_W'((longint'(1) << FRAC_BITS) - (longint'(iy) << FRAC_BITS) / gv);
        base = 0;
        for (int k = 0; k < f; k++)
            base += longint'(seg_of(u_axis_of(k)) + 1) * (seg_of(v_axis_of(k)) + 1);
        stride = gu + 1;
        v.quad_valid = (ix < gu) && (iy < gv);
        v.corner_a = '0;
        v.corner_b = '0;
        v.corner_c = '0;
        v.corner_d = '0;
        if (v.quad_valid) begin
            v.corner_a = IDX_W'(base + ix + stride * iy);
            v.corner_b = IDX_W'(base + ix + stride * (iy + 1));
            v.corner_c = IDX_W'(base + ix + 1 + stride * (iy + 1));
            v.corner_d = IDX_W'(base + ix + 1 + stride * iy);
        end
        return v;
    endfunction

    task automatic send_point(int f, int col, int rw);
        bit was_busy;
        if (idle_enable && $urandom_range(0, 99) < 4) begin
            start = 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start    = 1;
        i_face   = FACE_W'(f);
        i_column = COORD_W'(col);
        i_row    = COORD_W'(rw);
        forever begin
            was_busy = busy;
            @(posedge i_clk);
            if (!was_busy) break;
            @(negedge i_clk);
        end
        vertex_q.push_back(predict_vertex(f, col, rw));
        @(negedge i_clk);
        start = 0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        bit was_ready;
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        forever begin
            was_ready = o_cfg_ready;
            @(posedge i_clk);
            if (was_ready) break;
            @(negedge i_clk);
        end
        case (idx)
            CFG_BOX_WIDTH:       extent_q[0] = data;
            CFG_BOX_HEIGHT:      extent_q[1] = data;
            CFG_BOX_DEPTH:       extent_q[2] = data;
            CFG_WIDTH_SEGMENTS:  segs_q[0] = data[7:0];
            CFG_HEIGHT_SEGMENTS: segs_q[1] = data[7:0];
            CFG_DEPTH_SEGMENTS:  segs_q[2] = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic drain();
        while (vertex_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic set_box(int w, int h, int d, int sw, int sh, int sd);
        write_reg(CFG_BOX_WIDTH, DIM_W'(w));
        write_reg(CFG_BOX_HEIGHT, DIM_W'(h));
        write_reg(CFG_BOX_DEPTH, DIM_W'(d));
        write_reg(CFG_WIDTH_SEGMENTS, {16'($urandom_range(0, 65535)), 8'(sw)});
        write_reg(CFG_HEIGHT_SEGMENTS, {16'($urandom_range(0, 65535)), 8'(sh)});
        write_reg(CFG_DEPTH_SEGMENTS, {16'($urandom_range(0, 65535)), 8'(sd)});
    endtask

    task automatic send_random_point();
        int f, gu, gv;
        f  = $urandom_range(0, 7);
        gu = seg_of(u_axis_of(f > 5 ? 5 : f));
        gv = seg_of(v_axis_of(f > 5 ? 5 : f));
        if ($urandom_range(0, 3) == 0)
            send_point(f, $urandom_range(0, 255), $urandom_range(0, 255));
        else
            send_point(f, $urandom_range(0, gu), $urandom_range(0, gv));
    endtask

    task automatic test_reset_defaults();
        for (int f = 0; f < 8; f++) send_point(f, 0, 0);
        send_point(FACE_POS_X, 1, 1);
        send_point(FACE_NEG_Y, 255, 0);
        send_point(FACE_POS_Z, 0, 255);
        drain();
    endtask

    task automatic test_extremes();
        set_box(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 255, 255, 255);
        for (int f = 0; f < 6; f++) begin
            send_point(f, 255, 255);
            send_point(f, 254, 254);
            send_point(f, 0, 0);
        end
        drain();
        set_box(1, 1, 1, 0, 0, 0);
        send_point(FACE_NEG_X, 0, 0);
        send_point(FACE_POS_Y, 1, 1);
        drain();
        write_reg(CFG_SPARE_LO, 24'hFFFFFF);
        write_reg(CFG_SPARE_HI, 24'h000000);
        send_point(FACE_NEG_Z, 5, 0);
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 11; ph++) begin
            idle_enable = (ph != 4);
            set_box($urandom_range(0, 4) == 0 ? 24'hFFFFFF : $urandom_range(1, 24'hFFFFFF),
                    $urandom_range(1, 24'hFFFFFF),
                    $urandom_range(0, 4) == 0 ? 1 : $urandom_range(1, 24'hFFFFFF),
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 9),
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 9),
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 9));
            for (int n = 0; n < 150; n++) begin
                if (n == 75) begin
                    while (vertex_q.size() != 0) @(negedge i_clk);
                end
                send_random_point();
            end
            drain();
        end
        idle_enable = 1;
    endtask

    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_strobe) begin
            if (vertex_q.size() == 0) begin
                $error("unexpected result transaction");
                error_count++;
            end else begin
                e = vertex_q.pop_front();
                if (o_pos_x !== e.pos_x) begin
                    $error("pos_x exp %0d got %0d", e.pos_x, o_pos_x); error_count++;
                end
                if (o_pos_y !== e.pos_y) begin
                    $error("pos_y exp %0d got %0d", e.pos_y, o_pos_y); error_count++;
                end
                if (o_pos_z !== e.pos_z) begin
                    $error("pos_z exp %0d got %0d", e.pos_z, o_pos_z); error_count++;
                end
                if (o_normal_axis !== e.normal_axis) begin
                    $error("normal_axis exp %0d got %0d", e.normal_axis, o_normal_axis);
                    error_count++;
                end
                if (o_normal_negative !== e.normal_negative) begin
                    $error("normal_negative exp %0d got %0d", e.normal_negative,
                           o_normal_negative);
                    error_count++;
                end
                if (o_tex_u !== e.tex_u) begin
                    $error("tex_u exp %0d got %0d", e.tex_u, o_tex_u); error_count++;
                end
                if (o_tex_v !== e.tex_v) begin
                    $error("tex_v exp %0d got %0d", e.tex_v, o_tex_v); error_count++;
                end
                if (o_quad_valid !== e.quad_valid) begin
                    $error("quad_valid exp %0d got %0d", e.quad_valid, o_quad_valid);
                    error_count++;
                end
                if (o_corner_a !== e.corner_a) begin
                    $error("corner_a exp %0d got %0d", e.corner_a, o_corner_a); error_count++;
                end
                if (o_corner_b !== e.corner_b) begin
                    $error("corner_b exp %0d got %0d", e.corner_b, o_corner_b); error_count++;
                end
                if (o_corner_c !== e.corner_c) begin
                    $error("corner_c exp %0d got %0d", e.corner_c, o_corner_c); error_count++;
                end
                if (o_corner_d !== e.corner_d) begin
                    $error("corner_d exp %0d got %0d", e.corner_d, o_corner_d); error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 0;
        start       = 0;
        i_face      = 0;
        i_column    = 0;
        i_row       = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data  = 0;
        for (int a = 0; a < 3; a++) begin
            extent_q[a] = DIM_W'(1) << FRAC_BITS;
            segs_q[a]   = 1;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        test_reset_defaults();
        test_extremes();
        test_random_phases();

        if (vertex_q.size() != 0) begin
            $error("%0d results never arrived", vertex_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
